### sv/mpl_pkg.sv
// ----------------------------------------------------------------------------
// mpl_pkg
// Shared types, token codes and keyword tables for the mini Pascal lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package mpl_pkg;

  localparam int unsigned MAX_LEXEME_DEF    = 64;
  localparam int unsigned COUNTER_WIDTH_DEF = 16;
  localparam int unsigned RES_DEPTH         = 4;
  localparam int unsigned KW_COUNT          = 11;

  localparam logic [5:0] K_END          = 6'd0;
  localparam logic [5:0] K_ID           = 6'd1;
  localparam logic [5:0] K_KW0          = 6'd2;
  localparam logic [5:0] K_INT          = 6'd13;
  localparam logic [5:0] K_REAL         = 6'd14;
  localparam logic [5:0] K_PLUS         = 6'd15;
  localparam logic [5:0] K_MINUS        = 6'd16;
  localparam logic [5:0] K_STAR         = 6'd17;
  localparam logic [5:0] K_SLASH        = 6'd18;
  localparam logic [5:0] K_EQ           = 6'd19;
  localparam logic [5:0] K_DOT          = 6'd20;
  localparam logic [5:0] K_COMMA        = 6'd21;
  localparam logic [5:0] K_LPAREN       = 6'd22;
  localparam logic [5:0] K_RPAREN       = 6'd23;
  localparam logic [5:0] K_ASSIGN       = 6'd24;
  localparam logic [5:0] K_COLON        = 6'd25;
  localparam logic [5:0] K_SEMI         = 6'd26;
  localparam logic [5:0] K_GE           = 6'd27;
  localparam logic [5:0] K_GT           = 6'd28;
  localparam logic [5:0] K_LE           = 6'd29;
  localparam logic [5:0] K_NE           = 6'd30;
  localparam logic [5:0] K_LT           = 6'd31;
  localparam logic [5:0] K_BAD_CHAR     = 6'd32;
  localparam logic [5:0] K_BAD_REAL     = 6'd33;
  localparam logic [5:0] K_OPEN_COMMENT = 6'd34;

  typedef enum logic [3:0] {
    MODE_START,
    MODE_IDENT,
    MODE_INT,
    MODE_REAL_DOT,
    MODE_REAL_FRAC,
    MODE_COLON,
    MODE_GREATER,
    MODE_LESS,
    MODE_COMMENT
  } mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [6:0]  len;
    logic        last;
  } res_t;

  // keyword length
  function automatic logic [2:0] kw_len(input logic [3:0] idx);
    logic [2:0] l;
    case (idx)
      4'd0:    l = 3'd7;
      4'd1:    l = 3'd3;
      4'd2:    l = 3'd7;
      4'd3:    l = 3'd4;
      4'd4:    l = 3'd5;
      4'd5:    l = 3'd3;
      4'd6:    l = 3'd2;
      4'd7:    l = 3'd4;
      4'd8:    l = 3'd4;
      4'd9:    l = 3'd5;
      4'd10:   l = 3'd2;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  // keyword character at a position, lowercase
  function automatic logic [7:0] kw_char(input logic [3:0] idx, input logic [2:0] pos);
    logic [63:0] w;
    case (idx)
      4'd0:    w = {"program", 8'h00};
      4'd1:    w = {"var", 40'h0};
      4'd2:    w = {"integer", 8'h00};
      4'd3:    w = {"real", 32'h0};
      4'd4:    w = {"begin", 24'h0};
      4'd5:    w = {"end", 40'h0};
      4'd6:    w = {"if", 48'h0};
      4'd7:    w = {"then", 32'h0};
      4'd8:    w = {"else", 32'h0};
      4'd9:    w = {"while", 24'h0};
      4'd10:   w = {"do", 48'h0};
      default: w = 64'h0;
    endcase
    return w[63 - 8 * pos -: 8];
  endfunction

endpackage

`default_nettype wire

### sv/mpl_scan.sv
// ----------------------------------------------------------------------------
// mpl_scan
// Lexer state and one-step automaton: up to two tokens per source byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mpl_scan #(
  parameter int unsigned MAX_LEXEME    = mpl_pkg::MAX_LEXEME_DEF,
  parameter int unsigned COUNTER_WIDTH = mpl_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      char_i,
  input  wire logic            eoi_i,
  output mpl_pkg::res_t [1:0]  res_o,
  output logic [1:0]           res_cnt_o
);

  localparam int unsigned LCW = $clog2(MAX_LEXEME + 1);
  localparam int unsigned CW  = COUNTER_WIDTH;
  localparam logic [CW-1:0] CMAX = '1;
  localparam logic [mpl_pkg::KW_COUNT-1:0] KW_ALL = '1;

  mpl_pkg::mode_e mode_q, mode_d;
  logic [CW-1:0]  line_q, line_d, col_q, col_d, cline_q, cline_d, ccol_q, ccol_d;
  logic [CW-1:0]  tcol_q, tcol_d;
  logic [LCW-1:0] lex_q, lex_d;
  logic [mpl_pkg::KW_COUNT-1:0] mask_q, mask_d;

  logic [CW-1:0]  col_inc, line_inc, cur_col;
  logic           room, is_al, is_dg, is_dot, is_eq, is_gt, start;
  logic [7:0]     lc;
  logic [5:0]     id_kind;
  logic           a_vld, b_vld;
  logic [5:0]     a_kind, b_kind;
  logic [CW-1:0]  a_line, a_col, b_col;
  logic [6:0]     a_len, b_len;

  function automatic logic [mpl_pkg::KW_COUNT-1:0] mask_upd(
    input logic [mpl_pkg::KW_COUNT-1:0] m,
    input logic [LCW-1:0]               pos,
    input logic [7:0]                   ch
  );
    logic [mpl_pkg::KW_COUNT-1:0] r;
    r = m;
    for (int i = 0; i < mpl_pkg::KW_COUNT; i++) begin
      if (pos >= LCW'(mpl_pkg::kw_len(4'(i))) ||
          mpl_pkg::kw_char(4'(i), pos[2:0]) != ch) begin
        r[i] = 1'b0;
      end
    end
    return r;
  endfunction

  assign col_inc  = (col_q == CMAX) ? col_q : col_q + CW'(1);
  assign line_inc = (line_q == CMAX) ? line_q : line_q + CW'(1);
  assign cur_col  = eoi_i ? col_q : col_inc;
  assign room     = lex_q < LCW'(MAX_LEXEME);
  assign lc       = char_i | 8'h20;
  assign is_al    = !eoi_i && !char_i[7] && lc >= "a" && lc <= "z";
  assign is_dg    = !eoi_i && char_i >= "0" && char_i <= "9";
  assign is_dot   = !eoi_i && char_i == ".";
  assign is_eq    = !eoi_i && char_i == "=";
  assign is_gt    = !eoi_i && char_i == ">";

  always_comb begin
    id_kind = mpl_pkg::K_ID;
    for (int i = 0; i < mpl_pkg::KW_COUNT; i++) begin
      if (mask_q[i] && lex_q == LCW'(mpl_pkg::kw_len(4'(i)))) begin
        id_kind = mpl_pkg::K_KW0 + 6'(i);
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = cur_col;
    cline_d = cline_q;
    ccol_d  = ccol_q;
    tcol_d  = tcol_q;
    lex_d   = lex_q;
    mask_d  = mask_q;
    start   = 1'b0;
    a_vld   = 1'b0;
    a_kind  = mpl_pkg::K_END;
    a_line  = line_q;
    a_col   = tcol_q;
    a_len   = 7'd1;
    b_vld   = 1'b0;
    b_kind  = mpl_pkg::K_END;
    b_col   = cur_col;
    b_len   = 7'd1;

    // pending token
    case (mode_q)
      mpl_pkg::MODE_START: begin
        start = !eoi_i;
      end
      mpl_pkg::MODE_IDENT: begin
        if (room && (is_al || is_dg)) begin
          mask_d = mask_upd(mask_q, lex_q, is_al ? lc : char_i);
          lex_d  = lex_q + LCW'(1);
        end else begin
          a_vld  = 1'b1;
          a_kind = id_kind;
          a_len  = 7'(lex_q);
          mode_d = mpl_pkg::MODE_START;
          start  = !eoi_i;
        end
      end
      mpl_pkg::MODE_INT: begin
        if (room && is_dg) begin
          lex_d = lex_q + LCW'(1);
        end else if (room && is_dot) begin
          lex_d  = lex_q + LCW'(1);
          mode_d = mpl_pkg::MODE_REAL_DOT;
        end else begin
          a_vld  = 1'b1;
          a_kind = mpl_pkg::K_INT;
          a_len  = 7'(lex_q);
          mode_d = mpl_pkg::MODE_START;
          start  = !eoi_i;
        end
      end
      mpl_pkg::MODE_REAL_DOT: begin
        if (room && is_dg) begin
          lex_d  = lex_q + LCW'(1);
          mode_d = mpl_pkg::MODE_REAL_FRAC;
        end else begin
          a_vld  = 1'b1;
          a_kind = mpl_pkg::K_BAD_REAL;
          a_len  = 7'(lex_q);
          mode_d = mpl_pkg::MODE_START;
          start  = !eoi_i;
        end
      end
      mpl_pkg::MODE_REAL_FRAC: begin
        if (room && is_dg) begin
          lex_d = lex_q + LCW'(1);
        end else begin
          a_vld  = 1'b1;
          a_kind = mpl_pkg::K_REAL;
          a_len  = 7'(lex_q);
          mode_d = mpl_pkg::MODE_START;
          start  = !eoi_i;
        end
      end
      mpl_pkg::MODE_COLON: begin
        a_vld  = 1'b1;
        mode_d = mpl_pkg::MODE_START;
        if (is_eq) begin
          a_kind = mpl_pkg::K_ASSIGN;
          a_len  = 7'd2;
        end else begin
          a_kind = mpl_pkg::K_COLON;
          start  = !eoi_i;
        end
      end
      mpl_pkg::MODE_GREATER: begin
        a_vld  = 1'b1;
        mode_d = mpl_pkg::MODE_START;
        if (is_eq) begin
          a_kind = mpl_pkg::K_GE;
          a_len  = 7'd2;
        end else begin
          a_kind = mpl_pkg::K_GT;
          start  = !eoi_i;
        end
      end
      mpl_pkg::MODE_LESS: begin
        a_vld  = 1'b1;
        mode_d = mpl_pkg::MODE_START;
        if (is_eq) begin
          a_kind = mpl_pkg::K_LE;
          a_len  = 7'd2;
        end else if (is_gt) begin
          a_kind = mpl_pkg::K_NE;
          a_len  = 7'd2;
        end else begin
          a_kind = mpl_pkg::K_LT;
          start  = !eoi_i;
        end
      end
      mpl_pkg::MODE_COMMENT: begin
        if (eoi_i) begin
          a_vld  = 1'b1;
          a_kind = mpl_pkg::K_OPEN_COMMENT;
          a_line = cline_q;
          a_col  = ccol_q;
        end else if (char_i == "\n") begin
          line_d = line_inc;
          col_d  = '0;
        end else if (char_i == "}") begin
          mode_d = mpl_pkg::MODE_START;
        end
      end
      default: begin
        mode_d = mpl_pkg::MODE_START;
        start  = !eoi_i;
      end
    endcase

    if (eoi_i) begin
      mode_d = mpl_pkg::MODE_START;
      b_vld  = 1'b1;
      b_kind = mpl_pkg::K_END;
      b_len  = 7'd0;
    end

    // fresh scan from the start state
    if (start) begin
      case (char_i)
        " ", "\t", "\r": begin
        end
        "\n": begin
          line_d = line_inc;
          col_d  = '0;
        end
        "{": begin
          cline_d = line_q;
          ccol_d  = cur_col;
          mode_d  = mpl_pkg::MODE_COMMENT;
        end
        ":": begin
          mode_d = mpl_pkg::MODE_COLON;
          lex_d  = LCW'(1);
          tcol_d = cur_col;
        end
        ">": begin
          mode_d = mpl_pkg::MODE_GREATER;
          lex_d  = LCW'(1);
          tcol_d = cur_col;
        end
        "<": begin
          mode_d = mpl_pkg::MODE_LESS;
          lex_d  = LCW'(1);
          tcol_d = cur_col;
        end
        ";": begin b_vld = 1'b1; b_kind = mpl_pkg::K_SEMI;   end
        "+": begin b_vld = 1'b1; b_kind = mpl_pkg::K_PLUS;   end
        "-": begin b_vld = 1'b1; b_kind = mpl_pkg::K_MINUS;  end
        "*": begin b_vld = 1'b1; b_kind = mpl_pkg::K_STAR;   end
        "/": begin b_vld = 1'b1; b_kind = mpl_pkg::K_SLASH;  end
        "=": begin b_vld = 1'b1; b_kind = mpl_pkg::K_EQ;     end
        ".": begin b_vld = 1'b1; b_kind = mpl_pkg::K_DOT;    end
        ",": begin b_vld = 1'b1; b_kind = mpl_pkg::K_COMMA;  end
        "(": begin b_vld = 1'b1; b_kind = mpl_pkg::K_LPAREN; end
        ")": begin b_vld = 1'b1; b_kind = mpl_pkg::K_RPAREN; end
        default: begin
          if (is_al) begin
            mode_d = mpl_pkg::MODE_IDENT;
            lex_d  = LCW'(1);
            tcol_d = cur_col;
            mask_d = mask_upd(KW_ALL, '0, lc);
          end else if (is_dg) begin
            mode_d = mpl_pkg::MODE_INT;
            lex_d  = LCW'(1);
            tcol_d = cur_col;
          end else begin
            b_vld  = 1'b1;
            b_kind = mpl_pkg::K_BAD_CHAR;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_o[1].kind = b_kind;
    res_o[1].line = 16'(line_q);
    res_o[1].col  = 16'(eoi_i ? col_q : b_col);
    res_o[1].len  = b_len;
    res_o[1].last = 1'b1;
    if (a_vld) begin
      res_o[0].kind = a_kind;
      res_o[0].line = 16'(a_line);
      res_o[0].col  = 16'(a_col);
      res_o[0].len  = a_len;
      res_o[0].last = !b_vld;
    end else begin
      res_o[0] = res_o[1];
    end
    res_cnt_o = step_i ? (2'(a_vld) + 2'(b_vld)) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mpl_pkg::MODE_START;
      line_q  <= CW'(1);
      col_q   <= '0;
      cline_q <= '0;
      ccol_q  <= '0;
      tcol_q  <= '0;
      lex_q   <= '0;
      mask_q  <= KW_ALL;
    end else if (step_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      cline_q <= cline_d;
      ccol_q  <= ccol_d;
      tcol_q  <= tcol_d;
      lex_q   <= lex_d;
      mask_q  <= mask_d;
    end
  end

endmodule

`default_nettype wire

### sv/mpl_res_fifo.sv
// ----------------------------------------------------------------------------
// mpl_res_fifo
// Small token queue: takes up to two tokens a cycle, gives one a cycle when popped.
// ----------------------------------------------------------------------------
`default_nettype none

module mpl_res_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mpl_pkg::res_t [1:0] push_i,
  input  wire logic [1:0]          push_cnt_i,
  input  wire logic                pop_i,
  output logic                     room_o,
  output logic                     vld_o,
  output mpl_pkg::res_t            head_o
);

  localparam int unsigned DEPTH = mpl_pkg::RES_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);

  mpl_pkg::res_t mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          pop;

  assign vld_o  = cnt_q != '0;
  assign pop    = vld_o && pop_i;
  assign room_o = cnt_q <= (PW + 1)'(DEPTH - 2);
  assign head_o = mem_q[rd_q];

  assign wr_d  = wr_q + PW'(push_cnt_i);
  assign rd_d  = rd_q + PW'(pop);
  assign cnt_d = cnt_q + (PW + 1)'(push_cnt_i) - (PW + 1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_q + PW'(1)] <= push_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### sv/mini_pascal_lexer.sv
// ----------------------------------------------------------------------------
// mini_pascal_lexer
// Streaming lexer for a small Pascal subset, one source byte per item.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                  tuser         tlast
//  s_axis   in   [7:0] char_in                          end_of_input  -
//  m_axis   out  [5:0] kind [21:6] line [37:22] column  -             last_of_run
//                [44:38] length
//
//  An accepted item is registered, then lexed into a four-entry token queue
//  once the queue has room; the first token can leave the cycle after that.
//  Sustained rate is one item per cycle while each item gives at most one token
//  and the output is ready; an item giving two tokens queues both, given out singly.
//  Input is held off while an item waits and the queue has under two free entries.
//  Reset starts at line 1, column 0, start state, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module mini_pascal_lexer #(
  parameter int unsigned MAX_LEXEME    = mpl_pkg::MAX_LEXEME_DEF,
  parameter int unsigned COUNTER_WIDTH = mpl_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  wire logic        s_axis_tuser,   // [0] end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // kind, line, column, length, zero pad
  output logic             m_axis_tlast
);

  logic               in_vld_q, in_vld_d;
  logic [7:0]         in_char_q;
  logic               in_eoi_q;
  logic               step, room;
  mpl_pkg::res_t [1:0] res;
  logic [1:0]         res_cnt;
  mpl_pkg::res_t      head;

  assign step          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || step;
  assign in_vld_d      = s_axis_tvalid || (in_vld_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser;
    end
  end

  mpl_scan #(
    .MAX_LEXEME    (MAX_LEXEME),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .char_i    (in_char_q),
    .eoi_i     (in_eoi_q),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  mpl_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res),
    .push_cnt_i (res_cnt),
    .pop_i      (m_axis_tready),
    .room_o     (room),
    .vld_o      (m_axis_tvalid),
    .head_o     (head)
  );

  assign m_axis_tdata = {3'b000, head.len, head.col, head.line, head.kind};
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
